>>> sv/qphs_pkg.sv
`default_nettype none

package qphs_pkg;

    localparam int TABLE_SLOTS_DEF = 23;
    localparam int KEY_BYTES_DEF   = 8;

    localparam int KEY_W    = 64;
    localparam int STATUS_W = 3;
    localparam int ENTRY_W  = 4;
    localparam int HASH_W   = 18;
    localparam int BSUM_W   = 14;
    localparam int CHAR_MAX = 127;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] ST_STORED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HALF_FULL = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd4;

    typedef struct packed {
        logic             opcode;
        logic [KEY_W-1:0] key_bytes;
    } t_item_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [ENTRY_W-1:0]  entry_count;
        logic [HASH_W-1:0]   total_hash;
    } t_item_out;

    typedef struct packed {
        logic                load;
        logic                reduce;
        logic                probe;
        logic                write;
        logic                out_load;
        logic [STATUS_W-1:0] status;
        logic                found;
    } t_dp_cmd;

    typedef struct packed {
        logic reduce_last;
        logic key_ok;
        logic is_lookup;
        logic half_full;
        logic live;
        logic hit;
        logic empty;
        logic last;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> sv/qphs_dp.sv
`default_nettype none

module qphs_dp
    import qphs_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int KEY_BYTES   = KEY_BYTES_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_item_in  i_item,
    input  wire t_dp_cmd   i_cmd,
    output t_dp_stat       o_stat,
    output t_item_out      o_result
);

    localparam int SLOT_W   = $clog2(TABLE_SLOTS);
    localparam int IDX_W    = $clog2(TABLE_SLOTS + 1);
    localparam int CNT_W    = $clog2(TABLE_SLOTS / 2 + 1);
    localparam int SUM_W    = $clog2(KEY_BYTES * CHAR_MAX + 1);
    localparam int K_W      = 1;
    localparam int RECIP_SH = SUM_W + SLOT_W;
    localparam int RECIP_W  = SUM_W + 1;
    localparam int PROD_W   = SUM_W + RECIP_W;

    localparam logic [SLOT_W:0]    N_EXT    = (SLOT_W + 1)'(TABLE_SLOTS);
    localparam logic [IDX_W-1:0]   N_IDX    = IDX_W'(TABLE_SLOTS);
    localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
    localparam logic [CNT_W-1:0]   HALF_CNT = CNT_W'(TABLE_SLOTS / 2);
    localparam logic [SUM_W-1:0]   N_SUM    = SUM_W'(TABLE_SLOTS);
    localparam logic [RECIP_W-1:0] RECIP    =
        RECIP_W'(((1 << RECIP_SH) + TABLE_SLOTS - 1) / TABLE_SLOTS);
    localparam logic [K_W-1:0]     K_TOP    = K_W'(1);

    logic [KEY_W-1:0]  key_m;
    logic [SUM_W-1:0]  sum_c;
    logic              ok_c;
    logic              ended;
    logic              bad;
    logic [SLOT_W:0]   slot_sum;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W:0]   sq_sum;
    logic [SLOT_W:0]   odd_sum;
    logic [PROD_W-1:0] quo_prod;
    logic              issue;

    logic              r_op;
    logic [KEY_W-1:0]  r_key;
    logic [SUM_W-1:0]  r_sum;
    logic              r_ok;
    logic [SUM_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_quo;
    logic [K_W-1:0]    r_k;
    logic [IDX_W-1:0]  r_i;
    logic [SLOT_W-1:0] r_sq;
    logic [SLOT_W-1:0] r_odd;
    logic              r_live;
    logic              r_rd_last;
    logic              r_rd_occ;
    logic [SLOT_W-1:0] r_rd_slot;
    logic [KEY_W-1:0]  r_rd_key;
    logic [KEY_W-1:0]  r_mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] r_valid;
    logic [CNT_W-1:0]  r_count;
    logic [BSUM_W-1:0] r_bsum;
    t_item_out         r_out;

    always_comb begin
        key_m = '0;
        sum_c = '0;
        ended = 1'b0;
        bad   = 1'b0;
        for (int b = 0; b < KEY_W / 8; b++) begin
            if (b < KEY_BYTES) begin
                key_m[b*8 +: 8] = i_item.key_bytes[b*8 +: 8];
            end
        end
        for (int b = 0; b < KEY_W / 8; b++) begin
            if (key_m[b*8 + 7]) begin
                bad = 1'b1;
            end
            if (key_m[b*8 +: 8] == 8'h00) begin
                ended = 1'b1;
            end else if (ended) begin
                bad = 1'b1;
            end
        end
        for (int b = 0; b < KEY_BYTES; b++) begin
            sum_c = sum_c + SUM_W'(key_m[b*8 +: 7]);
        end
        ok_c = (key_m != '0) && !bad;
    end

    assign quo_prod = PROD_W'(r_sum) * PROD_W'(RECIP);
    assign slot_sum = (SLOT_W + 1)'(SLOT_W'(r_rem)) + {1'b0, r_sq};
    assign slot     = (slot_sum >= N_EXT) ? SLOT_W'(slot_sum - N_EXT) : SLOT_W'(slot_sum);
    assign sq_sum   = {1'b0, r_sq} + {1'b0, r_odd};
    assign odd_sum  = {1'b0, r_odd} + (SLOT_W + 1)'(2);
    assign issue    = i_cmd.probe && (r_i != N_IDX);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_item.opcode;
            r_key <= key_m;
            r_sum <= sum_c;
            r_ok  <= ok_c;
            r_k   <= K_TOP;
            r_i   <= '0;
            r_sq  <= '0;
            r_odd <= SLOT_W'(1);
        end else begin
            if (i_cmd.reduce) begin
                if (r_k != '0) begin
                    r_quo <= SUM_W'(quo_prod >> RECIP_SH);
                end else begin
                    r_rem <= r_sum - SUM_W'(r_quo * N_SUM);
                end
                r_k <= r_k - K_W'(1);
            end
            if (issue) begin
                r_i   <= r_i + IDX_W'(1);
                r_sq  <= (sq_sum >= N_EXT) ? SLOT_W'(sq_sum - N_EXT) : SLOT_W'(sq_sum);
                r_odd <= (odd_sum >= N_EXT) ? SLOT_W'(odd_sum - N_EXT) : SLOT_W'(odd_sum);
            end
        end
        if (issue) begin
            r_rd_key  <= r_mem[slot];
            r_rd_occ  <= r_valid[slot];
            r_rd_slot <= slot;
            r_rd_last <= (r_i == LAST_IDX);
        end
        if (i_cmd.write) begin
            r_mem[r_rd_slot] <= r_key;
        end
        if (i_cmd.out_load) begin
            r_out.status      <= i_cmd.status;
            r_out.found       <= i_cmd.found;
            r_out.entry_count <= ENTRY_W'(r_count);
            r_out.total_hash  <= HASH_W'(r_bsum) * HASH_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            r_bsum  <= '0;
            r_live  <= 1'b0;
        end else begin
            r_live <= issue && !i_cmd.load;
            if (i_cmd.write) begin
                r_valid[r_rd_slot] <= 1'b1;
                r_count            <= r_count + CNT_W'(1);
                r_bsum             <= r_bsum + BSUM_W'(r_sum);
            end
        end
    end

    assign o_stat.reduce_last = (r_k == '0);
    assign o_stat.key_ok      = r_ok;
    assign o_stat.is_lookup   = (r_op == OP_LOOKUP);
    assign o_stat.half_full   = (r_count >= HALF_CNT);
    assign o_stat.live        = r_live;
    assign o_stat.hit         = r_rd_occ && (r_rd_key == r_key);
    assign o_stat.empty       = !r_rd_occ;
    assign o_stat.last        = r_rd_last;
    assign o_result           = r_out;

endmodule

`default_nettype wire

>>> sv/qphs_ctrl.sv
`default_nettype none

module qphs_ctrl
    import qphs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          o_busy,
    output logic          o_done
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_REDUCE,
        S_PROBE,
        S_FINISH
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;
    logic                r_found;
    logic                n_found;
    logic                r_done;
    logic                n_done;

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_found  = r_found;
        n_done   = 1'b0;
        o_cmd    = '0;
        o_cmd.status = r_status;
        o_cmd.found  = r_found;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_REDUCE;
                end
            end
            S_REDUCE: begin
                o_cmd.reduce = 1'b1;
                if (i_stat.reduce_last) begin
                    n_found = 1'b0;
                    if (!i_stat.key_ok) begin
                        n_status = ST_INVALID;
                        n_state  = S_FINISH;
                    end else if (!i_stat.is_lookup && i_stat.half_full) begin
                        n_status = ST_HALF_FULL;
                        n_state  = S_FINISH;
                    end else begin
                        n_state = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                o_cmd.probe = 1'b1;
                if (i_stat.live) begin
                    if (i_stat.hit) begin
                        n_status = i_stat.is_lookup ? ST_STORED : ST_PRESENT;
                        n_found  = i_stat.is_lookup;
                        n_state  = S_FINISH;
                    end else if (!i_stat.is_lookup && i_stat.empty) begin
                        o_cmd.write = 1'b1;
                        n_status    = ST_STORED;
                        n_state     = S_FINISH;
                    end else if (i_stat.last) begin
                        n_status = i_stat.is_lookup ? ST_STORED : ST_EXHAUSTED;
                        n_state  = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                o_cmd.out_load = 1'b1;
                n_done         = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_STORED;
            r_found  <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_found  <= n_found;
            r_done   <= n_done;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

`default_nettype wire

>>> sv/quadratic_probe_hash_set.sv
// Hash set of short keys (up to eight 7-bit characters, zero padded).
// Input: pulse start with i_item while busy is low; that beat is taken.
//   opcode 0 inserts the key, 1 looks it up.
// Output: o_done is high for one cycle with o_result: status, found,
//   entry_count and total_hash. There is no backpressure; the receiver
//   must take the beat in that cycle.
// Flow: the home slot comes from a reciprocal multiply, then one
//   multiply and subtract. The slot store is walked with one
//   quadratic probe a cycle, read data registered, and the S_FINISH
//   state then forms the result. An invalid key or a refused insert
//   skips the probe pass.
// Throughput: one item at a time; busy falls as the result beat is shown,
//   so the next start may coincide with o_done.
// Reset: synchronous, active low; the occupancy bits, entry count and hash
//   total clear, and the set is empty at once.
`default_nettype none

module quadratic_probe_hash_set
    import qphs_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int KEY_BYTES   = KEY_BYTES_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire t_item_in i_item,
    output logic          busy,
    output logic          o_done,
    output t_item_out     o_result
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    qphs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    qphs_dp #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KEY_BYTES   (KEY_BYTES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (o_result)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held longer than one cycle");

    a_write_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.write |-> stat.live && stat.empty && !stat.is_lookup)
        else $error("slot write without an empty probed slot");

    a_found_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.found |-> o_result.status == ST_STORED)
        else $error("found flag with a non-lookup status");

endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import qphs_pkg::*;

    localparam int N_SLOTS      = TABLE_SLOTS_DEF;
    localparam int PHASE_ITEMS  = 434;
    localparam int MAX_GAP      = 40;
    localparam int TAIL_CYCLES  = 40;
    localparam int POOL_DEPTH   = 64;
    localparam logic [KEY_W-1:0] KEY_MASK =
        (KEY_BYTES_DEF >= 8) ? {KEY_W{1'b1}} : ((64'd1 << (8 * KEY_BYTES_DEF)) - 64'd1);

    typedef struct packed {
        t_item_in  beat;
        logic      typed;
        t_item_out result;
    } t_stim_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    t_item_in  i_item;
    logic      busy;
    logic      o_done;
    t_item_out o_result;

    logic [KEY_W-1:0]  slot_store [N_SLOTS] = '{default: '0};
    int unsigned       stored_keys = 0;
    logic [BSUM_W-1:0] byte_sum_acc = '0;

    t_item_out        queued_outcomes [$];
    logic [KEY_W-1:0] key_pool [$];
    t_stim_row        stim_rows [$];
    t_item_out        want_beat;

    int error_count  = 0;
    int beats_sent   = 0;
    int results_seen = 0;
    int lookup_hits  = 0;
    int status_tally [5] = '{default: 0};

    quadratic_probe_hash_set dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    function automatic t_item_out probe_and_update(t_item_in beat);
        t_item_out        res;
        logic [KEY_W-1:0] key;
        logic [7:0]       ch;
        int unsigned      sum;
        int unsigned      home;
        int unsigned      slot;
        bit               ok;
        bit               ended;
        bit               done;
        key   = beat.key_bytes & KEY_MASK;
        res   = '0;
        sum   = 0;
        ok    = (key != '0);
        ended = 1'b0;
        done  = 1'b0;
        for (int b = 0; b < 8; b++) begin
            ch = key[8*b +: 8];
            if (ch[7])
                ok = 1'b0;
            else if (ch == 8'h00)
                ended = 1'b1;
            else if (ended)
                ok = 1'b0;
            sum += ch;
        end
        if (!ok) begin
            res.status = ST_INVALID;
        end else begin
            home = sum % N_SLOTS;
            if (beat.opcode == OP_LOOKUP) begin
                res.status = ST_STORED;
                for (int unsigned i = 0; i < N_SLOTS; i++) begin
                    if (slot_store[(home + (i * i) % N_SLOTS) % N_SLOTS] == key)
                        res.found = 1'b1;
                end
            end else if (stored_keys >= N_SLOTS / 2) begin
                res.status = ST_HALF_FULL;
            end else begin
                res.status = ST_EXHAUSTED;
                for (int unsigned i = 0; i < N_SLOTS; i++) begin
                    slot = (home + (i * i) % N_SLOTS) % N_SLOTS;
                    if (!done && slot_store[slot] == key) begin
                        res.status = ST_PRESENT;
                        done = 1'b1;
                    end else if (!done && slot_store[slot] == '0) begin
                        slot_store[slot] = key;
                        stored_keys++;
                        byte_sum_acc = BSUM_W'(byte_sum_acc + sum);
                        res.status = ST_STORED;
                        done = 1'b1;
                    end
                end
            end
        end
        res.entry_count = stored_keys[ENTRY_W-1:0];
        res.total_hash  = HASH_W'(byte_sum_acc * stored_keys);
        return res;
    endfunction

    function automatic t_stim_row typed_row(logic op, logic [KEY_W-1:0] key,
                                            logic [STATUS_W-1:0] status);
        t_stim_row r;
        r = '0;
        r.beat.opcode    = op;
        r.beat.key_bytes = key;
        r.typed          = 1'b1;
        r.result.status  = status;
        return r;
    endfunction

    function automatic t_stim_row model_row(logic op, logic [KEY_W-1:0] key);
        t_stim_row r;
        r = '0;
        r.beat.opcode    = op;
        r.beat.key_bytes = key;
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] well_formed_key();
        logic [KEY_W-1:0] k;
        int               len;
        k   = '0;
        len = $urandom_range(1, 8);
        for (int b = 0; b < len; b++)
            k[8*b +: 8] = 8'($urandom_range(1, CHAR_MAX));
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] next_key();
        logic [KEY_W-1:0] k;
        int               pick;
        int               b;
        pick = $urandom_range(0, 99);
        if (pick < 25 && key_pool.size() != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        k = well_formed_key();
        if (pick >= 85) begin
            b = $urandom_range(0, 6);
            if ($urandom_range(0, 1) == 0) begin
                k[8*b + 7] = 1'b1;
            end else begin
                k[8*b +: 8] = 8'h00;
                k[63:56]    = 8'($urandom_range(1, CHAR_MAX));
            end
        end else if (pick >= 70) begin
            k = {$urandom, $urandom};
        end
        return k;
    endfunction

    task automatic flag_error(string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("result %0d %s got %0h want %0h", results_seen, name, got, want));
    endtask

    task automatic send_beat(t_item_in beat, logic typed, t_item_out typed_result);
        t_item_out predicted;
        start  <= 1'b1;
        i_item <= beat;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted = probe_and_update(beat);
        queued_outcomes.push_back(typed ? typed_result : predicted);
        beats_sent++;
        if (beat.key_bytes != '0) begin
            key_pool.push_back(beat.key_bytes);
            if (key_pool.size() > POOL_DEPTH)
                void'(key_pool.pop_front());
        end
    endtask

    task automatic rest(int pct);
        if ($urandom_range(0, 99) < pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (queued_outcomes.size() != 0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (queued_outcomes.size() == 0) begin
                flag_error($sformatf("unexpected result beat %h", o_result));
            end else begin
                want_beat = queued_outcomes.pop_front();
                check_field("status", 32'(o_result.status), 32'(want_beat.status));
                check_field("found", 32'(o_result.found), 32'(want_beat.found));
                check_field("entry_count", 32'(o_result.entry_count),
                            32'(want_beat.entry_count));
                check_field("total_hash", 32'(o_result.total_hash),
                            32'(want_beat.total_hash));
                if (want_beat.status <= ST_INVALID)
                    status_tally[want_beat.status]++;
                if (want_beat.found)
                    lookup_hits++;
            end
            results_seen++;
        end
    end

    initial begin
        t_item_in beat;
        int       idle_pct;
        int       directed_count;

        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;

        stim_rows.push_back(typed_row(OP_LOOKUP, 64'h41, ST_STORED));
        stim_rows.push_back(typed_row(OP_INSERT, 64'h0, ST_INVALID));
        stim_rows.push_back(typed_row(OP_LOOKUP, 64'h0, ST_INVALID));
        stim_rows.push_back(typed_row(OP_INSERT, 64'h80, ST_INVALID));
        stim_rows.push_back(typed_row(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, ST_INVALID));
        stim_rows.push_back(typed_row(OP_INSERT, 64'h0000_0000_0041_0041, ST_INVALID));
        stim_rows.push_back(typed_row(OP_INSERT, 64'h7F00_0000_0000_0041, ST_INVALID));
        stim_rows.push_back(typed_row(OP_INSERT, 64'h0000_0000_0000_8041, ST_INVALID));
        stim_rows.push_back(model_row(OP_INSERT, 64'h7F7F_7F7F_7F7F_7F7F));
        stim_rows.push_back(model_row(OP_INSERT, 64'h41));
        stim_rows.push_back(model_row(OP_INSERT, 64'h41));
        stim_rows.push_back(model_row(OP_LOOKUP, 64'h41));
        stim_rows.push_back(model_row(OP_LOOKUP, 64'h7F7F_7F7F_7F7F_7F7F));
        stim_rows.push_back(model_row(OP_INSERT, 64'h01));
        stim_rows.push_back(model_row(OP_INSERT, 64'h4001));
        stim_rows.push_back(model_row(OP_INSERT, 64'h3F02));
        stim_rows.push_back(model_row(OP_INSERT, 64'h3E03));
        stim_rows.push_back(model_row(OP_INSERT, 64'h58));
        stim_rows.push_back(model_row(OP_INSERT, 64'h6F));
        stim_rows.push_back(model_row(OP_INSERT, 64'h2A));
        stim_rows.push_back(model_row(OP_INSERT, 64'h20_2020));
        stim_rows.push_back(model_row(OP_INSERT, 64'h42));
        stim_rows.push_back(model_row(OP_INSERT, 64'h43));
        stim_rows.push_back(model_row(OP_INSERT, 64'h41));
        stim_rows.push_back(model_row(OP_LOOKUP, 64'h43));
        stim_rows.push_back(model_row(OP_LOOKUP, 64'h3E03));
        directed_count = stim_rows.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[r]) begin
            send_beat(stim_rows[r].beat, stim_rows[r].typed, stim_rows[r].result);
            rest(6);
        end
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 6 : (phase == 1) ? 56 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                beat.opcode    = ($urandom_range(0, 1) == 0) ? OP_INSERT : OP_LOOKUP;
                beat.key_bytes = next_key();
                send_beat(beat, 1'b0, '0);
                rest(idle_pct);
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run covered: %0d beats (%0d directed), %0d results, %0d lookup hits",
                 beats_sent, directed_count, results_seen, lookup_hits);
        $display("run covered: stored %0d, present %0d, half full %0d, exhausted %0d, invalid %0d",
                 status_tally[ST_STORED], status_tally[ST_PRESENT], status_tally[ST_HALF_FULL],
                 status_tally[ST_EXHAUSTED], status_tally[ST_INVALID]);
        if (error_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
